### rtl/aesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_pkg
// Shared types and character codes for the escape sequence stripper.
// ----------------------------------------------------------------------------
package aesc_pkg;

	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_LBR = 8'h5b;
	localparam logic [7:0] CH_RBR = 8'h5d;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] FIN_LO = 8'h40;
	localparam logic [7:0] FIN_HI = 8'h7e;

	typedef enum logic [4:0] {
		MODE_NORMAL  = 5'b00001,
		MODE_ESC     = 5'b00010,
		MODE_CSI     = 5'b00100,
		MODE_OSC     = 5'b01000,
		MODE_OSC_ESC = 5'b10000
	} mode_t;

	// One queue entry: the results caused by one input byte.
	typedef struct packed {
		logic       esc_pre;     // emit a held ESC ahead of the data byte
		logic       data_valid;  // data byte is kept
		logic       eot;         // last input byte of the text
		logic [7:0] data;
	} cmd_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/aesc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_in_if / aesc_out_if
// Valid/ready channels for raw input bytes and for filtered results.
// ----------------------------------------------------------------------------
interface aesc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface aesc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       end_of_text;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output end_of_text, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input run_last,
		input end_of_text, output ready);
endinterface

### rtl/aesc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_front
// Scan mode tracker: classifies each input byte and queues what it keeps and each end of text.
// ----------------------------------------------------------------------------
module aesc_front (
	input  logic                clk,
	input  logic                arst_n,
	aesc_in_if.sink             in_ch,
	input  aesc_pkg::q_stat_t   q_stat,
	output logic                push,
	output aesc_pkg::cmd_t      cmd
);

	aesc_pkg::mode_t mode_q;
	aesc_pkg::mode_t mode_d;
	logic            esc_pre;
	logic            keep;
	logic            in_fire;
	logic [7:0]      b;
	logic            last;

	assign b       = in_ch.data_byte;
	assign last    = in_ch.is_last;
	assign in_ch.ready = !q_stat.full;
	assign in_fire = in_ch.valid && in_ch.ready;

	always_comb begin
		mode_d  = mode_q;
		esc_pre = 1'b0;
		keep    = 1'b0;
		case (mode_q)
			aesc_pkg::MODE_ESC: begin
				if (b == aesc_pkg::CH_LBR) begin
					mode_d = aesc_pkg::MODE_CSI;
				end else if (b == aesc_pkg::CH_RBR) begin
					mode_d = aesc_pkg::MODE_OSC;
				end else begin
					// held ESC is kept, byte then looked at as plain text
					esc_pre = 1'b1;
					if (b == aesc_pkg::CH_ESC && !last) begin
						mode_d = aesc_pkg::MODE_ESC;
					end else begin
						keep   = 1'b1;
						mode_d = aesc_pkg::MODE_NORMAL;
					end
				end
			end
			aesc_pkg::MODE_CSI: begin
				if (b inside {[aesc_pkg::FIN_LO:aesc_pkg::FIN_HI]})
					mode_d = aesc_pkg::MODE_NORMAL;
			end
			aesc_pkg::MODE_OSC, aesc_pkg::MODE_OSC_ESC: begin
				if (mode_q == aesc_pkg::MODE_OSC_ESC && b == aesc_pkg::CH_BSL)
					mode_d = aesc_pkg::MODE_NORMAL;
				else if (b == aesc_pkg::CH_BEL)
					mode_d = aesc_pkg::MODE_NORMAL;
				else if (b == aesc_pkg::CH_ESC)
					mode_d = aesc_pkg::MODE_OSC_ESC;
				else
					mode_d = aesc_pkg::MODE_OSC;
			end
			default: begin
				if (b == aesc_pkg::CH_ESC && !last) begin
					mode_d = aesc_pkg::MODE_ESC;
				end else begin
					keep   = 1'b1;
					mode_d = aesc_pkg::MODE_NORMAL;
				end
			end
		endcase
		if (last)
			mode_d = aesc_pkg::MODE_NORMAL;
	end

	// A byte that keeps nothing and does not end the text leaves no entry.
	assign push           = in_fire && (esc_pre || keep || last);
	assign cmd.esc_pre    = esc_pre;
	assign cmd.data_valid = keep;
	assign cmd.eot        = last;
	assign cmd.data       = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= aesc_pkg::MODE_NORMAL;
		end else if (in_fire) begin
			mode_q <= mode_d;
		end
	end

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q)) else $error("scan mode not one-hot");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> mode_q == aesc_pkg::MODE_NORMAL)
		else $error("mode not normal after end of text");

endmodule

### rtl/aesc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_queue
// Small register FIFO of pending result entries between front and back.
// ----------------------------------------------------------------------------
module aesc_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  aesc_pkg::cmd_t     wr_cmd,
	input  logic               pop,
	output aesc_pkg::cmd_t     head,
	output aesc_pkg::q_stat_t  q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	aesc_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full)) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty)) else $error("pop from empty queue");

endmodule

### rtl/aesc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_back
// Result sequencer: turns each queue entry into one or two output transactions.
// ----------------------------------------------------------------------------
module aesc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  aesc_pkg::cmd_t     head,
	input  aesc_pkg::q_stat_t  q_stat,
	output logic               pop,
	aesc_out_if.source         out_ch
);

	logic phase_q;   // held ESC already sent, data byte pending
	logic emit_esc;
	logic fire;
	logic final_res;

	assign emit_esc  = head.esc_pre && !phase_q;
	assign final_res = !(emit_esc && head.data_valid);

	assign out_ch.valid       = !q_stat.empty;
	assign out_ch.out_byte    = emit_esc ? aesc_pkg::CH_ESC
		: (head.data_valid ? head.data : 8'h00);
	assign out_ch.byte_valid  = emit_esc || head.data_valid;
	assign out_ch.run_last    = final_res;
	assign out_ch.end_of_text = head.eot && final_res;

	assign fire = out_ch.valid && out_ch.ready;
	assign pop  = fire && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (fire) begin
			phase_q <= !final_res;
		end
	end

	a_phase_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!q_stat.empty && head.esc_pre && head.data_valid))
		else $error("second phase without a two-result entry");

endmodule

### rtl/ansi_escape_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_stripper
// Removes CSI and OSC terminal escape sequences from a byte stream.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | data_byte[7:0], is_last
//  out_ch  | out | valid / ready | out_byte[7:0], byte_valid, run_last, end_of_text
//
//  One input byte per cycle unless the queue is full; the mode register
//  updates in the cycle of acceptance. A byte that yields two results
//  (held ESC plus byte) takes two output transactions from the registered queue.
//  in_ch.ready drops only when the QUEUE_DEPTH-entry queue is full.
//  arst_n clears scan mode, queue and output phase; no other init time.
// ----------------------------------------------------------------------------
module ansi_escape_stripper #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	aesc_in_if.sink     in_ch,
	aesc_out_if.source  out_ch
);

	aesc_pkg::cmd_t    cmd;
	aesc_pkg::cmd_t    head;
	aesc_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	aesc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (cmd)
	);

	aesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	aesc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape sequence stripper. A short directed
// list covers plain bytes at the extremes, CSI and OSC bodies and
// terminators, ESC pairs and the end-of-text cases. Random texts of mostly
// well-formed sequences with noise and cut-off tails follow. Every accepted
// byte runs through a local model of the filter. Every output transaction is
// checked in order against the queue of results from the model or the typed rows.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1750;
	localparam int N_DIR       = 27;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       end_of_text;
	} res_t;

	typedef struct {
		logic [7:0] d;
		logic       last;
		bit         typed;
		int         n;
		res_t       e0;
		res_t       e1;
	} stim_row_t;

	localparam res_t R_NONE = '{8'h00, 1'b0, 1'b0, 1'b0};

	// Rows with typed set carry their own expected results.
	stim_row_t dir_rows [0:N_DIR-1] = '{
		'{8'h41,  1'b0, 1'b1, 1, '{8'h41, 1'b1, 1'b1, 1'b0}, R_NONE},
		'{8'h00,  1'b0, 1'b1, 1, '{8'h00, 1'b1, 1'b1, 1'b0}, R_NONE},
		'{8'hff,  1'b0, 1'b1, 1, '{8'hff, 1'b1, 1'b1, 1'b0}, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_LBR, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{8'h33,  1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{8'h7f,  1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::FIN_LO, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_RBR, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_BEL, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_RBR, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{8'h79,  1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_BSL, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b1, 1,
			'{aesc_pkg::CH_ESC, 1'b1, 1'b1, 1'b0}, R_NONE},
		'{8'h41,  1'b0, 1'b1, 2, '{aesc_pkg::CH_ESC, 1'b1, 1'b0, 1'b0},
			'{8'h41, 1'b1, 1'b1, 1'b0}},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_LBR, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::FIN_HI, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{aesc_pkg::CH_LBR, 1'b0, 1'b0, 0, R_NONE, R_NONE},
		'{8'h31,  1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1}, R_NONE},
		'{aesc_pkg::CH_ESC, 1'b1, 1'b1, 1,
			'{aesc_pkg::CH_ESC, 1'b1, 1'b1, 1'b1}, R_NONE}
	};

	logic clk = 1'b0;
	logic arst_n;

	aesc_in_if  in_ch ();
	aesc_out_if out_ch ();

	ansi_escape_stripper u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	aesc_pkg::mode_t scan_st = aesc_pkg::MODE_NORMAL;
	res_t       kept_q [$];
	logic [7:0] text_q [$];
	int         fail_cnt = 0;
	int         cyc_cnt = 0;
	int         sent_cnt = 0;
	int         tx_idle_pct = 33;
	int         rx_idle_pct = 62;

	// Side info for the byte currently on the input channel
	bit         cur_typed;
	int         cur_n;
	res_t       cur_e0;
	res_t       cur_e1;

	// Filter model: consumes one byte, returns the results it causes.
	task automatic strip_step(input logic [7:0] d, input logic last, output int n,
		output res_t r0, output res_t r1);
		res_t            r [2];
		aesc_pkg::mode_t nxt;
		bit              do_plain;
		bit              do_osc;
		n = 0;
		r[0] = R_NONE;
		r[1] = R_NONE;
		nxt = scan_st;
		do_plain = 1'b0;
		do_osc = 1'b0;
		case (scan_st)
			aesc_pkg::MODE_ESC: begin
				if (d == aesc_pkg::CH_LBR) begin
					nxt = aesc_pkg::MODE_CSI;
				end else if (d == aesc_pkg::CH_RBR) begin
					nxt = aesc_pkg::MODE_OSC;
				end else begin
					r[n] = '{aesc_pkg::CH_ESC, 1'b1, 1'b0, 1'b0};
					n++;
					do_plain = 1'b1;
				end
			end
			aesc_pkg::MODE_CSI: begin
				nxt = (d >= aesc_pkg::FIN_LO && d <= aesc_pkg::FIN_HI)
					? aesc_pkg::MODE_NORMAL : aesc_pkg::MODE_CSI;
			end
			aesc_pkg::MODE_OSC: begin
				do_osc = 1'b1;
			end
			aesc_pkg::MODE_OSC_ESC: begin
				if (d == aesc_pkg::CH_BSL)
					nxt = aesc_pkg::MODE_NORMAL;
				else
					do_osc = 1'b1;
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase
		if (do_plain) begin
			if (d == aesc_pkg::CH_ESC && !last) begin
				nxt = aesc_pkg::MODE_ESC;
			end else begin
				r[n] = '{d, 1'b1, 1'b0, 1'b0};
				n++;
				nxt = aesc_pkg::MODE_NORMAL;
			end
		end
		if (do_osc) begin
			if (d == aesc_pkg::CH_BEL)
				nxt = aesc_pkg::MODE_NORMAL;
			else if (d == aesc_pkg::CH_ESC)
				nxt = aesc_pkg::MODE_OSC_ESC;
			else
				nxt = aesc_pkg::MODE_OSC;
		end
		if (last) begin
			if (n == 0) begin
				r[0] = R_NONE;
				n = 1;
			end
			r[n-1].end_of_text = 1'b1;
			nxt = aesc_pkg::MODE_NORMAL;
		end
		if (n > 0)
			r[n-1].run_last = 1'b1;
		scan_st = nxt;
		r0 = r[0];
		r1 = r[1];
	endtask

	// Monitor: check output transactions, then predict from input transactions.
	always @(posedge clk) begin
		res_t act;
		res_t ex;
		res_t p0;
		res_t p1;
		int   pn;
		cyc_cnt <= cyc_cnt + 1;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				act = '{out_ch.out_byte, out_ch.byte_valid, out_ch.run_last,
					out_ch.end_of_text};
				if (kept_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("ERROR: unexpected result %h/%b/%b/%b",
							act.out_byte, act.byte_valid, act.run_last, act.end_of_text);
				end else begin
					ex = kept_q.pop_front();
					if (act.out_byte !== ex.out_byte || act.byte_valid !== ex.byte_valid ||
						act.run_last !== ex.run_last || act.end_of_text !== ex.end_of_text) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("ERROR: exp %h/%b/%b/%b got %h/%b/%b/%b",
								ex.out_byte, ex.byte_valid, ex.run_last, ex.end_of_text,
								act.out_byte, act.byte_valid, act.run_last, act.end_of_text);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				strip_step(in_ch.data_byte, in_ch.is_last, pn, p0, p1);
				if (cur_typed) begin
					pn = cur_n;
					p0 = cur_e0;
					p1 = cur_e1;
				end
				if (pn > 0)
					kept_q.push_back(p0);
				if (pn > 1)
					kept_q.push_back(p1);
			end
		end
	end

	always @(posedge clk) begin
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
		else
			out_ch.ready = 1'b0;
	end

	// Entered at a falling edge; returns at the falling edge after the transaction.
	task automatic send_byte(input logic [7:0] d, input logic last, input bit typed,
		input int n, input res_t e0, input res_t e1);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.data_byte = d;
		in_ch.is_last = last;
		cur_typed = typed;
		cur_n = n;
		cur_e0 = e0;
		cur_e1 = e1;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic build_text();
		int         nseg;
		int         k;
		int         cut;
		logic [7:0] b;
		text_q.delete();
		nseg = $urandom_range(1, 8);
		for (int s = 0; s < nseg; s++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					b = 8'($urandom_range(255));
					if (b == aesc_pkg::CH_ESC)
						b = 8'h20;
					text_q.push_back(b);
				end
				4, 5: begin
					text_q.push_back(aesc_pkg::CH_ESC);
					text_q.push_back(aesc_pkg::CH_LBR);
					k = $urandom_range(4);
					for (int i = 0; i < k; i++)
						text_q.push_back(8'($urandom_range(8'h20, 8'h3f)));
					text_q.push_back(8'($urandom_range(aesc_pkg::FIN_LO, aesc_pkg::FIN_HI)));
				end
				6: begin
					text_q.push_back(aesc_pkg::CH_ESC);
					text_q.push_back(aesc_pkg::CH_RBR);
					k = $urandom_range(6);
					for (int i = 0; i < k; i++) begin
						b = 8'($urandom_range(255));
						if (b == aesc_pkg::CH_ESC || b == aesc_pkg::CH_BEL)
							b = 8'h3b;
						text_q.push_back(b);
					end
					if ($urandom_range(1)) begin
						text_q.push_back(aesc_pkg::CH_BEL);
					end else begin
						text_q.push_back(aesc_pkg::CH_ESC);
						text_q.push_back(aesc_pkg::CH_BSL);
					end
				end
				7: begin
					b = 8'($urandom_range(255));
					if (b == aesc_pkg::CH_LBR || b == aesc_pkg::CH_RBR)
						b = 8'h4d;
					text_q.push_back(aesc_pkg::CH_ESC);
					text_q.push_back(b);
				end
				8: begin
					text_q.push_back(8'($urandom_range(255)));
				end
				default: begin
					// broken sequences: lone ESC, or ESC inside OSC followed by a random byte
					text_q.push_back(aesc_pkg::CH_ESC);
					if ($urandom_range(1)) begin
						text_q.push_back(aesc_pkg::CH_RBR);
						text_q.push_back(8'($urandom_range(255)));
						text_q.push_back(aesc_pkg::CH_ESC);
						text_q.push_back(8'($urandom_range(255)));
					end
				end
			endcase
		end
		// sometimes cut the tail so a sequence is left open at end of text
		if ($urandom_range(3) == 0) begin
			cut = $urandom_range(1, text_q.size());
			while (text_q.size() > cut)
				void'(text_q.pop_back());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.is_last = 1'b0;
		cur_typed = 1'b0;
		cur_n = 0;
		cur_e0 = R_NONE;
		cur_e1 = R_NONE;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_byte(dir_rows[i].d, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].n,
				dir_rows[i].e0, dir_rows[i].e1);

		while (sent_cnt < RAND_ITEMS) begin
			if (sent_cnt < RAND_ITEMS / 3) begin
				tx_idle_pct = 33;
				rx_idle_pct = 62;
			end else if (sent_cnt < 2 * RAND_ITEMS / 3) begin
				tx_idle_pct = 62;
				rx_idle_pct = 33;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			build_text();
			for (int i = 0; i < text_q.size(); i++)
				send_byte(text_q[i], (i == text_q.size() - 1), 1'b0, 0, R_NONE, R_NONE);
		end
		in_ch.valid = 1'b0;

		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
